// File: sv/rbd_pkg.sv
package rbd_pkg;

    // Request codes carried on req_type
    localparam logic [2:0] REQ_PUSH_BACK  = 3'd0;
    localparam logic [2:0] REQ_PUSH_FRONT = 3'd1;
    localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [2:0] REQ_POP_BACK   = 3'd3;
    localparam logic [2:0] REQ_PEEK       = 3'd4;
    localparam logic [2:0] REQ_REPLACE    = 3'd5;

    // Per-request tally saturates here
    localparam logic [8:0] TALLY_MAX = 9'd256;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic latch;    // capture the incoming transaction
        logic exec;     // access memory, update pointers
        logic respond;  // present the result
    } t_cmd;

endpackage

// File: sv/ring_byte_deque_top.sv
// Byte deque over a ring of DEPTH bytes. Raise start with a request while busy
// is low; the transaction is taken on that edge and busy stays high until the
// result has gone out. After the accepting edge the controller passes through
// ST_EXEC (one access of the single-port byte memory, read registered) and
// then ST_RESP, which raises the result strobe. A new request can be accepted
// the cycle after the strobe. The result appears for exactly one
// cycle on o_strobe and cannot be held off, so the receiver must take it
// then. Refused pushes, pops, peeks and replaces leave the state untouched
// and report o_accepted low. o_request_count counts accepted bytes of the
// current request and clears after a result with o_request_done set.
module ring_byte_deque_top
    import rbd_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] i_req_type,
    input  logic [7:0] i_byte_in,
    input  logic [7:0] i_offset,
    input  logic       i_last_of_request,
    output logic       o_strobe,
    output logic [7:0] o_byte_out,
    output logic       o_accepted,
    output logic [8:0] o_request_count,
    output logic       o_request_done,
    output logic [8:0] o_fill_count
);

    t_cmd cmd;

    rbd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    rbd_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_req_type        (i_req_type),
        .i_byte_in         (i_byte_in),
        .i_offset          (i_offset),
        .i_last_of_request (i_last_of_request),
        .o_strobe          (o_strobe),
        .o_byte_out        (o_byte_out),
        .o_accepted        (o_accepted),
        .o_request_count   (o_request_count),
        .o_request_done    (o_request_done),
        .o_fill_count      (o_fill_count)
    );

endmodule

// File: sv/rbd_ctrl.sv
module rbd_ctrl
    import rbd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        busy          = 1'b1;
        case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = ST_RESP;
            end
            ST_RESP: begin
                o_cmd.respond = 1'b1;
                n_state       = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// File: sv/rbd_datapath.sv
module rbd_datapath
    import rbd_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  logic [2:0] i_req_type,
    input  logic [7:0] i_byte_in,
    input  logic [7:0] i_offset,
    input  logic       i_last_of_request,
    output logic       o_strobe,
    output logic [7:0] o_byte_out,
    output logic       o_accepted,
    output logic [8:0] o_request_count,
    output logic       o_request_done,
    output logic [8:0] o_fill_count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int W     = CNT_W + 8;
    localparam logic [W-1:0]     DEPTH_W = W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(DEPTH - 1);

    // Captured transaction
    logic [2:0] r_kind;
    logic [7:0] r_data;
    logic [7:0] r_off;
    logic       r_last;

    // Deque state
    logic [PTR_W-1:0] r_front;
    logic [PTR_W-1:0] n_front;
    logic [CNT_W-1:0] r_held;
    logic [CNT_W-1:0] n_held;
    logic [8:0]       r_tally;

    // Result flags and read data
    logic       r_taken;
    logic       r_read;
    logic [7:0] r_rd;

    logic [7:0] mem [DEPTH];

    // Exec-cycle decode
    logic             taken;
    logic             mem_we;
    logic             mem_re;
    logic             use_dec;
    logic [W-1:0]     x_sel;
    logic [W-1:0]     front_ext;
    logic [W-1:0]     held_ext;
    logic [W-1:0]     off_ext;
    logic [W-1:0]     sum;
    logic [W-1:0]     pos_w;
    logic [PTR_W-1:0] front_dec;
    logic [PTR_W-1:0] front_inc;
    logic [PTR_W-1:0] addr;
    logic [W-1:0]     fill_ext;

    assign front_ext = {{(W - PTR_W){1'b0}}, r_front};
    assign held_ext  = {8'd0, r_held};
    assign off_ext   = {{CNT_W{1'b0}}, r_off};
    assign front_dec = (r_front == '0) ? LAST_P : r_front - PTR_W'(1);
    assign front_inc = (r_front == LAST_P) ? '0 : r_front + PTR_W'(1);

    // Ring position: front plus distance, one wrap at most
    assign sum   = front_ext + x_sel;
    assign pos_w = (sum >= DEPTH_W) ? sum - DEPTH_W : sum;
    assign addr  = use_dec ? front_dec : pos_w[PTR_W-1:0];

    always_comb begin
        taken   = 1'b0;
        mem_we  = 1'b0;
        mem_re  = 1'b0;
        use_dec = 1'b0;
        x_sel   = '0;
        n_front = r_front;
        n_held  = r_held;
        case (r_kind)
            REQ_PUSH_BACK: begin
                x_sel = held_ext;
                if (held_ext < DEPTH_W) begin
                    taken  = 1'b1;
                    mem_we = 1'b1;
                    n_held = r_held + CNT_W'(1);
                end
            end
            REQ_PUSH_FRONT: begin
                use_dec = 1'b1;
                if (held_ext < DEPTH_W) begin
                    taken   = 1'b1;
                    mem_we  = 1'b1;
                    n_front = front_dec;
                    n_held  = r_held + CNT_W'(1);
                end
            end
            REQ_POP_FRONT: begin
                if (r_held != '0) begin
                    taken   = 1'b1;
                    mem_re  = 1'b1;
                    n_front = front_inc;
                    n_held  = r_held - CNT_W'(1);
                end
            end
            REQ_POP_BACK: begin
                x_sel = held_ext - W'(1);
                if (r_held != '0) begin
                    taken  = 1'b1;
                    mem_re = 1'b1;
                    n_held = r_held - CNT_W'(1);
                end
            end
            REQ_PEEK: begin
                x_sel = off_ext;
                if (off_ext < held_ext) begin
                    taken  = 1'b1;
                    mem_re = 1'b1;
                end
            end
            REQ_REPLACE: begin
                x_sel = off_ext;
                if (off_ext < held_ext) begin
                    taken  = 1'b1;
                    mem_we = 1'b1;
                end
            end
            default: begin
                taken = 1'b0;
            end
        endcase
    end

    // Transaction capture, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_kind <= i_req_type;
            r_data <= i_byte_in;
            r_off  <= i_offset;
            r_last <= i_last_of_request;
        end
    end

    // Single-port byte store, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && mem_we) begin
            mem[addr] <= r_data;
        end
        if (i_cmd.exec && mem_re) begin
            r_rd <= mem[addr];
        end
    end

    // Pointers, fill and request tally
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_held  <= '0;
            r_tally <= '0;
            r_taken <= 1'b0;
            r_read  <= 1'b0;
        end else if (i_cmd.exec) begin
            r_front <= n_front;
            r_held  <= n_held;
            r_taken <= taken;
            r_read  <= mem_re;
            if (taken && (r_tally < TALLY_MAX)) begin
                r_tally <= r_tally + 9'd1;
            end
        end else if (i_cmd.respond && r_last) begin
            r_tally <= '0;
        end
    end

    // Result ports
    assign fill_ext        = {8'd0, r_held};
    assign o_strobe        = i_cmd.respond;
    assign o_byte_out      = r_read ? r_rd : 8'd0;
    assign o_accepted      = r_taken;
    assign o_request_count = r_tally;
    assign o_request_done  = r_last;
    assign o_fill_count    = fill_ext[8:0];

endmodule

// File: sv/rbd_checker.sv
module rbd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_strobe,
    input logic [7:0] o_byte_out,
    input logic       o_accepted,
    input logic [8:0] o_request_count
);

    // Every accepted transaction yields a result strobe
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_strobe)
        else $error("result strobe missing after accepted transaction");

    // Busy covers the whole transaction
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // Ready again right after the result
    a_free_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !busy)
        else $error("busy still high after result");

    // Refused operations read back zero
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_accepted) |-> (o_byte_out == 8'd0))
        else $error("nonzero byte on refused transaction");

    // An accepted byte always counts toward the request
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_accepted) |-> (o_request_count != 9'd0))
        else $error("request count zero on accepted transaction");

endmodule

bind ring_byte_deque_top rbd_checker u_rbd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_strobe        (o_strobe),
    .o_byte_out      (o_byte_out),
    .o_accepted      (o_accepted),
    .o_request_count (o_request_count)
);
